// File: rtl/core/mvpp_pkg.sv
// Shared types, widths and modular helper functions for the polymatrix product core.
package mvpp_pkg;

    localparam int CB = 60;   // coefficient and modulus width

    typedef struct packed {
        logic [CB-1:0] weight;
        logic [CB-1:0] coefficient;
    } in_beat_t;

    typedef struct packed {
        logic [CB-1:0] sum_value;
        logic [15:0]   column_index;
        logic [11:0]   coeff_index;
        logic          last_of_column;
    } out_beat_t;

    typedef struct packed {
        logic [CB-1:0] modulus;
        logic [15:0]   row_count;
        logic [15:0]   col_count;
        logic [12:0]   coeffs_in_use;
    } cfg_t;

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_MODULUS = 2'd0,
        REG_ROWS    = 2'd1,
        REG_COLS    = 2'd2,
        REG_COEFFS  = 2'd3
    } reg_idx_t;

    // accumulator reduction sequencer
    typedef enum logic [1:0] {
        RED_IDLE = 2'd0,
        RED_RUN  = 2'd1,
        RED_DONE = 2'd2
    } red_state_t;

    // reduce t < 2p into [0, p)
    function automatic logic [CB-1:0] red_lt2(input logic [CB:0] t, input logic [CB-1:0] p);
        logic [CB:0] d;
        d = t - {1'b0, p};
        return (t >= {1'b0, p}) ? d[CB-1:0] : t[CB-1:0];
    endfunction

    // reduce t < 3p into [0, p)
    function automatic logic [CB-1:0] red_lt3(input logic [CB+1:0] t, input logic [CB-1:0] p);
        logic [CB+1:0] p1;
        logic [CB+1:0] p2;
        logic [CB+1:0] d1;
        logic [CB+1:0] d2;
        p1 = {2'b00, p};
        p2 = {1'b0, p, 1'b0};
        d1 = t - p1;
        d2 = t - p2;
        if (t >= p2)
            return d2[CB-1:0];
        else if (t >= p1)
            return d1[CB-1:0];
        else
            return t[CB-1:0];
    endfunction

    // (a + b) mod p for a, b < p
    function automatic logic [CB-1:0] add_mod(input logic [CB-1:0] a, input logic [CB-1:0] b,
                                              input logic [CB-1:0] p);
        logic [CB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return red_lt2(s, p);
    endfunction

endpackage

// File: rtl/core/mvpp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mvpp_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/mvpp_cfg.sv
// APB-style configuration registers of the polymatrix product core.
module mvpp_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output mvpp_pkg::cfg_t cfg
);
    import mvpp_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t sel;

    assign sel = reg_idx_t'(paddr[4:3]);

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (sel)
                REG_MODULUS: cfg_next.modulus       = pwdata[CB-1:0];
                REG_ROWS:    cfg_next.row_count     = pwdata[15:0];
                REG_COLS:    cfg_next.col_count     = pwdata[15:0];
                REG_COEFFS:  cfg_next.coeffs_in_use = pwdata[12:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.modulus       <= CB'(65537);
            cfg_reg.row_count     <= 16'd1;
            cfg_reg.col_count     <= 16'd1;
            cfg_reg.coeffs_in_use <= 13'd4096;
        end
        else
            cfg_reg <= cfg_next;
    end

    // read-back mux
    always_comb
    begin
        unique case (sel)
            REG_MODULUS: prdata = 64'(cfg_reg.modulus);
            REG_ROWS:    prdata = 64'(cfg_reg.row_count);
            REG_COLS:    prdata = 64'(cfg_reg.col_count);
            REG_COEFFS:  prdata = 64'(cfg_reg.coeffs_in_use);
            default:     prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;
endmodule

// File: rtl/core/mvpp_mulmod.sv
// Bit-serial pipelined (w * c) mod p: CB stages reduce w, then CB stages double-and-add c.
module mvpp_mulmod #(
    parameter int SW = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic [mvpp_pkg::CB-1:0] p,
    input  logic                   in_vld,
    input  logic [mvpp_pkg::CB-1:0] in_w,
    input  logic [mvpp_pkg::CB-1:0] in_c,
    input  logic [SW-1:0]          in_sb,
    output logic                   out_vld,
    output logic [mvpp_pkg::CB-1:0] out_prod,
    output logic [SW-1:0]          out_sb
);
    import mvpp_pkg::*;

    localparam int NS = 2 * CB;

    logic          vld_reg [1:NS];
    logic [SW-1:0] sb_reg  [1:NS];
    // reduction half
    logic [CB-1:0] wr_reg [1:CB];
    logic [CB-1:0] cr_reg [1:CB];
    logic [CB-1:0] rr_reg [1:CB];
    // multiply half
    logic [CB-1:0] ar_reg [1:CB];
    logic [CB-1:0] cb_reg [1:CB];
    logic [CB-1:0] pr_reg [1:CB];

    // valid and sideband travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= NS; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[1] <= in_vld;
            for (int k = 2; k <= NS; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[1] <= in_sb;
            for (int k = 2; k <= NS; k++)
                sb_reg[k] <= sb_reg[k-1];
        end
    end

    // weight reduction: r = (2r + w bit) mod p, MSB first
    for (genvar k = 1; k <= CB; k++) begin : g_red
        logic [CB-1:0] w_prev;
        logic [CB-1:0] c_prev;
        logic [CB-1:0] r_prev;
        logic [CB:0]   t;
        if (k == 1) begin : g_first
            assign w_prev = in_w;
            assign c_prev = in_c;
            assign r_prev = '0;
        end
        else begin : g_rest
            assign w_prev = wr_reg[k-1];
            assign c_prev = cr_reg[k-1];
            assign r_prev = rr_reg[k-1];
        end
        assign t = {r_prev, w_prev[CB-k]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                wr_reg[k] <= w_prev;
                cr_reg[k] <= c_prev;
                rr_reg[k] <= red_lt2(t, p);
            end
        end
    end

    // multiply: r = (2r + c bit * a) mod p, MSB first
    for (genvar j = 1; j <= CB; j++) begin : g_mul
        logic [CB-1:0] a_prev;
        logic [CB-1:0] c_prev;
        logic [CB-1:0] r_prev;
        logic [CB+1:0] t;
        if (j == 1) begin : g_first
            assign a_prev = rr_reg[CB];
            assign c_prev = cr_reg[CB];
            assign r_prev = '0;
        end
        else begin : g_rest
            assign a_prev = ar_reg[j-1];
            assign c_prev = cb_reg[j-1];
            assign r_prev = pr_reg[j-1];
        end
        assign t = {1'b0, r_prev, 1'b0} + (c_prev[CB-j] ? {2'b00, a_prev} : '0);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ar_reg[j] <= a_prev;
                cb_reg[j] <= c_prev;
                pr_reg[j] <= red_lt3(t, p);
            end
        end
    end

    assign out_vld  = vld_reg[NS];
    assign out_sb   = sb_reg[NS];
    assign out_prod = pr_reg[CB];
endmodule

// File: rtl/core/modular_vector_polymatrix_product_core.sv
// Top level: sequencing, modular product pipeline and accumulator read-modify-write.
//
//  channel | direction | handshake         | beat
//  in      | input     | in_valid/in_ready  | in_beat_t  (weight, coefficient)
//  out     | output    | out_valid/out_ready| out_beat_t (sum, column, coeff, last)
//  cfg     | input     | APB psel/penable   | 64-bit register write/read
//
// One item per cycle sustained when not stalled; results pass the bit-serial
// modular multiplier (60 reduce stages, 60 double-and-add stages) and the
// accumulator RAM read. Reset clears positions and pipeline valids; the
// accumulator RAM is not cleared (row 0 writes fresh). The pipeline stalls while
// both output registers hold results and the next one is ready to emit, and
// while a stored accumulator not below a newly written modulus is reduced.
module modular_vector_polymatrix_product_core #(
    parameter int MAX_COEFFS = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mvpp_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mvpp_pkg::out_beat_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);
    import mvpp_pkg::*;

    localparam int IW = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
    // sideband: {first_row, emit, last_coef, column[15:0], pos[IW-1:0]}
    localparam int SW       = IW + 19;
    localparam int SB_FIRST = IW + 18;
    localparam int SB_EMIT  = IW + 17;
    localparam int SB_LASTC = IW + 16;

    cfg_t            cfg;
    logic [CB-1:0]   p;
    logic [16:0]     rows;
    logic [16:0]     cols;
    logic [16:0]     ncoef;
    logic            adv;
    logic            acc_in;

    logic [15:0]     row_pos_reg,  row_pos_next;
    logic [15:0]     col_pos_reg,  col_pos_next;
    logic [IW-1:0]   coef_pos_reg, coef_pos_next;
    logic            last_row, last_coef, last_col;
    logic [SW-1:0]   in_sb;

    logic            mm_vld;
    logic [CB-1:0]   mm_prod;
    logic [SW-1:0]   mm_sb;

    logic            s_vld_reg;
    logic [CB-1:0]   s_prod_reg;
    logic [SW-1:0]   s_sb_reg;
    logic            fwd_reg;
    logic [CB-1:0]   fwd_data_reg;
    logic [CB-1:0]   ram_rdata;
    logic [CB-1:0]   raw_base;
    logic [CB-1:0]   base;
    logic [CB-1:0]   sum;
    logic            s_emit;
    logic            stall;
    logic            base_big;
    logic            red_hold;
    logic            out_hold;

    red_state_t      red_state_reg, red_state_next;
    logic [5:0]      red_cnt_reg,   red_cnt_next;
    logic [CB-1:0]   red_acc_reg,   red_acc_next;

    logic            push;
    logic            pop;
    out_beat_t       emit_beat;
    logic            out_valid_reg;
    out_beat_t       out_data_reg;
    logic            skid_vld_reg;
    out_beat_t       skid_data_reg;

    mvpp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );
    assign pready = 1'b1;

    // effective limits
    always_comb
    begin
        p     = (cfg.modulus == '0) ? CB'(1) : cfg.modulus;
        rows  = (cfg.row_count == '0) ? 17'd1 : {1'b0, cfg.row_count};
        cols  = (cfg.col_count == '0) ? 17'd1 : {1'b0, cfg.col_count};
        if (cfg.coeffs_in_use == '0)
            ncoef = 17'd1;
        else if ({4'b0, cfg.coeffs_in_use} > 17'(MAX_COEFFS))
            ncoef = 17'(MAX_COEFFS);
        else
            ncoef = {4'b0, cfg.coeffs_in_use};
    end

    // stall when both output registers are full and a result waits to emit, or while a stale accumulator is reduced
    assign s_emit   = s_sb_reg[SB_EMIT];
    assign out_hold = s_vld_reg && s_emit && skid_vld_reg;
    assign stall    = out_hold || red_hold;
    assign adv      = !stall;
    assign in_ready = adv;
    assign acc_in   = in_valid && adv;

    // position sequencer
    always_comb
    begin
        last_row  = ({1'b0, row_pos_reg} + 17'd1) >= rows;
        last_coef = (17'(coef_pos_reg) + 17'd1) >= ncoef;
        last_col  = ({1'b0, col_pos_reg} + 17'd1) >= cols;
        row_pos_next  = row_pos_reg;
        col_pos_next  = col_pos_reg;
        coef_pos_next = coef_pos_reg;
        if (acc_in)
        begin
            if (last_coef)
            begin
                coef_pos_next = '0;
                if (last_row)
                begin
                    row_pos_next = '0;
                    col_pos_next = last_col ? 16'd0 : col_pos_reg + 16'd1;
                end
                else
                    row_pos_next = row_pos_reg + 16'd1;
            end
            else
                coef_pos_next = coef_pos_reg + IW'(1);
        end
        in_sb = {(row_pos_reg == '0), last_row, last_coef, col_pos_reg, coef_pos_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
            coef_pos_reg <= '0;
        end
        else
        begin
            row_pos_reg  <= row_pos_next;
            col_pos_reg  <= col_pos_next;
            coef_pos_reg <= coef_pos_next;
        end
    end

    mvpp_mulmod #(.SW(SW)) u_mulmod (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .p        (p),
        .in_vld   (acc_in),
        .in_w     (in_data.weight),
        .in_c     (in_data.coefficient),
        .in_sb    (in_sb),
        .out_vld  (mm_vld),
        .out_prod (mm_prod),
        .out_sb   (mm_sb)
    );

    // accumulate stage; a stored value left over from a larger modulus is reduced first
    assign raw_base = fwd_reg ? fwd_data_reg : ram_rdata;
    assign base_big = s_vld_reg && !s_sb_reg[SB_FIRST] && (raw_base >= p);
    assign red_hold = base_big && (red_state_reg != RED_DONE);
    assign base     = s_sb_reg[SB_FIRST] ? '0 :
                      ((red_state_reg == RED_DONE) ? red_acc_reg : raw_base);
    assign sum      = add_mod(base, s_prod_reg, p);

    // reduction sequencer: next state
    always_comb
    begin
        red_state_next = red_state_reg;
        unique case (red_state_reg)
            RED_IDLE: if (red_hold) red_state_next = RED_RUN;
            RED_RUN:  if (red_cnt_reg == 6'(CB-1)) red_state_next = RED_DONE;
            RED_DONE: if (adv) red_state_next = RED_IDLE;
            default:  red_state_next = RED_IDLE;
        endcase
    end

    // reduction datapath: r = (2r + bit) mod p over the stalled value, MSB first
    always_comb
    begin
        red_cnt_next = red_cnt_reg;
        red_acc_next = red_acc_reg;
        unique case (red_state_reg)
            RED_IDLE:
            begin
                red_cnt_next = '0;
                red_acc_next = '0;
            end
            RED_RUN:
            begin
                red_cnt_next = red_cnt_reg + 6'd1;
                red_acc_next = red_lt2({red_acc_reg, raw_base[6'(CB-1) - red_cnt_reg]}, p);
            end
            RED_DONE: red_cnt_next = red_cnt_reg;
            default:  red_cnt_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            red_state_reg <= RED_IDLE;
        else
            red_state_reg <= red_state_next;
    end

    always_ff @(posedge clk)
    begin
        red_cnt_reg <= red_cnt_next;
        red_acc_reg <= red_acc_next;
    end

    mvpp_ram #(.WIDTH(CB), .DEPTH(MAX_COEFFS)) u_acc_ram (
        .clk   (clk),
        .we    (adv && s_vld_reg),
        .waddr (s_sb_reg[IW-1:0]),
        .wdata (sum),
        .re    (adv && mm_vld),
        .raddr (mm_sb[IW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_vld_reg <= 1'b0;
        else if (adv)
            s_vld_reg <= mm_vld;
    end

    // forward the sum being written to an item reading the same entry
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_prod_reg   <= mm_prod;
            s_sb_reg     <= mm_sb;
            fwd_reg      <= s_vld_reg && (mm_sb[IW-1:0] == s_sb_reg[IW-1:0]);
            fwd_data_reg <= sum;
        end
    end

    // result beat from the accumulate stage
    assign push = adv && s_vld_reg && s_emit;
    assign pop  = out_valid_reg && out_ready;

    always_comb
    begin
        emit_beat.sum_value      = sum;
        emit_beat.column_index   = s_sb_reg[IW+15:IW];
        emit_beat.coeff_index    = 12'(s_sb_reg[IW-1:0]);
        emit_beat.last_of_column = s_sb_reg[SB_LASTC];
    end

    // output register plus skid register, so out_ready never reaches in_ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_vld_reg  <= 1'b0;
        end
        else if (pop || !out_valid_reg)
        begin
            if (skid_vld_reg)
            begin
                out_valid_reg <= 1'b1;
                skid_vld_reg  <= push;
            end
            else
                out_valid_reg <= push;
        end
        else if (push)
            skid_vld_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (pop || !out_valid_reg)
        begin
            if (skid_vld_reg)
            begin
                out_data_reg <= skid_data_reg;
                if (push)
                    skid_data_reg <= emit_beat;
            end
            else if (push)
                out_data_reg <= emit_beat;
        end
        else if (push)
            skid_data_reg <= emit_beat;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
endmodule

// File: tb/sv/tb_modular_vector_polymatrix_product_core.sv
// Testbench for the modular vector times polynomial-matrix product core.
`timescale 1ns / 1ps

module tb_modular_vector_polymatrix_product_core;
    import mvpp_pkg::*;

    localparam int NCOEF_MAX = 4096;
    localparam int DRAIN_CYCLES = 150;
    localparam logic [CB-1:0] ALL_ONES = {CB{1'b1}};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_beat_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_beat_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    modular_vector_polymatrix_product_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor state: configuration, accumulators and stream positions
    cfg_t            mdl_cfg;
    logic [CB-1:0]   acc_mem [NCOEF_MAX];
    bit              acc_written [NCOEF_MAX];
    int unsigned     row_pos;
    int unsigned     col_pos;
    int unsigned     coef_pos;
    out_beat_t       expected_sums[$];

    int unsigned     mismatch_count;
    int unsigned     tx_idle_pct;
    int unsigned     rx_idle_pct;
    int unsigned     rx_hold_left;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #200ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int unsigned eff_coeffs(input logic [12:0] v);
        if (v == 0)
            return 1;
        if (v > NCOEF_MAX)
            return NCOEF_MAX;
        return v;
    endfunction

    function automatic logic [CB-1:0] eff_modulus();
        return (mdl_cfg.modulus < 2) ? 1 : mdl_cfg.modulus;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH %s: expected %0h, got %0h", what, exp_v, act_v);
    endtask

    // one multiply-accumulate step of the product, queues the finished coefficient
    task automatic accumulate_coefficient(input logic [CB-1:0] w, input logic [CB-1:0] c);
        logic [CB-1:0]   p;
        logic [2*CB-1:0] prod;
        logic [CB:0]     sum;
        logic [CB-1:0]   base;
        int unsigned     rows;
        int unsigned     cols;
        int unsigned     ncoef;
        int unsigned     idx;
        bit              last_row;
        bit              last_coef;
        out_beat_t       res;
        p = eff_modulus();
        rows = (mdl_cfg.row_count == 0) ? 1 : mdl_cfg.row_count;
        cols = (mdl_cfg.col_count == 0) ? 1 : mdl_cfg.col_count;
        ncoef = eff_coeffs(mdl_cfg.coeffs_in_use);
        prod = ((w % p) * (c % p)) % p;
        idx = (coef_pos < NCOEF_MAX) ? coef_pos : NCOEF_MAX - 1;
        base = (row_pos == 0) ? '0 : acc_mem[idx] % p;
        sum = ({1'b0, base} + {1'b0, prod[CB-1:0]}) % {1'b0, p};
        acc_mem[idx] = sum[CB-1:0];
        acc_written[idx] = 1'b1;
        last_row = (row_pos + 1 >= rows);
        last_coef = (coef_pos + 1 >= ncoef);
        if (last_row)
        begin
            res.sum_value = sum[CB-1:0];
            res.column_index = col_pos[15:0];
            res.coeff_index = coef_pos[11:0];
            res.last_of_column = last_coef;
            expected_sums.push_back(res);
        end
        if (last_coef)
        begin
            coef_pos = 0;
            if (last_row)
            begin
                row_pos = 0;
                col_pos = (col_pos + 1 >= cols) ? 0 : col_pos + 1;
            end
            else
                row_pos++;
        end
        else
            coef_pos++;
    endtask

    // register access over the configuration port; writes are checked by read-back in write_register
    task automatic apb_access(input reg_idx_t r, input bit wr, input logic [63:0] v,
                              output logic [63:0] rd);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = 5'(r) << 3;
        pwdata = v;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic check_register(input reg_idx_t r);
        logic [63:0] rd;
        logic [63:0] exp_v;
        apb_access(r, 1'b0, '0, rd);
        case (r)
            REG_MODULUS: exp_v = 64'(mdl_cfg.modulus);
            REG_ROWS:    exp_v = 64'(mdl_cfg.row_count);
            REG_COLS:    exp_v = 64'(mdl_cfg.col_count);
            default:     exp_v = 64'(mdl_cfg.coeffs_in_use);
        endcase
        if (rd != exp_v)
            note_mismatch($sformatf("register %s", r.name()), exp_v, rd);
    endtask

    task automatic write_register(input reg_idx_t r, input logic [63:0] v);
        logic [63:0] rd;
        apb_access(r, 1'b1, v, rd);
        case (r)
            REG_MODULUS: mdl_cfg.modulus = v[CB-1:0];
            REG_ROWS:    mdl_cfg.row_count = v[15:0];
            REG_COLS:    mdl_cfg.col_count = v[15:0];
            default:     mdl_cfg.coeffs_in_use = v[12:0];
        endcase
        check_register(r);
    endtask

    // coefficient count that never reads an accumulator unwritten since reset
    function automatic logic [12:0] safe_coeffs(input logic [12:0] want);
        int unsigned first_gap;
        if (row_pos == 0)
            return want;
        first_gap = NCOEF_MAX;
        for (int i = NCOEF_MAX - 1; i >= 0; i--)
            if (!acc_written[i])
                first_gap = i;
        return (eff_coeffs(want) > first_gap) ? 13'(first_gap) : want;
    endfunction

    task automatic configure(input logic [CB-1:0] p, input logic [15:0] rows,
                             input logic [15:0] cols, input logic [12:0] ncoef);
        write_register(REG_MODULUS, 64'(p));
        write_register(REG_ROWS, 64'(rows));
        write_register(REG_COLS, 64'(cols));
        write_register(REG_COEFFS, 64'(safe_coeffs(ncoef)));
    endtask

    // wait for every queued result, then until the input side has stayed open long
    // enough for every item still in the pipeline to pass the accumulate stage
    task automatic wait_idle();
        int unsigned quiet;
        while (expected_sums.size() != 0)
            @(posedge clk);
        quiet = 0;
        while (quiet < DRAIN_CYCLES)
        begin
            @(negedge clk);
            quiet = in_ready ? quiet + 1 : 0;
        end
    endtask

    // one beat on the input channel, predicted once accepted
    task automatic send_item(input logic [CB-1:0] w, input logic [CB-1:0] c);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_data.weight = w;
        in_data.coefficient = c;
        do
            @(posedge clk);
        while (!in_ready);
        accumulate_coefficient(w, c);
    endtask

    task automatic end_burst();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic logic [CB-1:0] pick_value();
        logic [CB-1:0] p;
        p = eff_modulus();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return p - 1;
            3:       return p;
            4, 5:    return {$urandom, $urandom} % p;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [CB-1:0] pick_modulus();
        case ($urandom_range(11))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return ALL_ONES;
            4:       return 65537;
            5, 6:    return $urandom_range(3, 1000);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // receiver: random stalls plus an optional long hold-off
    always @(negedge clk)
    begin
        if (rx_hold_left != 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        out_beat_t exp_b;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_sums.size() == 0)
                note_mismatch("unexpected result", '0, 64'(out_data.sum_value));
            else
            begin
                exp_b = expected_sums.pop_front();
                if (out_data.sum_value != exp_b.sum_value)
                    note_mismatch("sum_value", 64'(exp_b.sum_value), 64'(out_data.sum_value));
                if (out_data.column_index != exp_b.column_index)
                    note_mismatch("column_index", 64'(exp_b.column_index),
                                  64'(out_data.column_index));
                if (out_data.coeff_index != exp_b.coeff_index)
                    note_mismatch("coeff_index", 64'(exp_b.coeff_index),
                                  64'(out_data.coeff_index));
                if (out_data.last_of_column != exp_b.last_of_column)
                    note_mismatch("last_of_column", 64'(exp_b.last_of_column),
                                  64'(out_data.last_of_column));
            end
        end
    end

    // reset values, then single-row products at the reset configuration
    task automatic test_reset_config();
        check_register(REG_MODULUS);
        check_register(REG_ROWS);
        check_register(REG_COLS);
        check_register(REG_COEFFS);
        send_item('0, ALL_ONES);
        send_item(ALL_ONES, 60'd65536);
        send_item(60'd65536, 60'd65537);
        send_item(ALL_ONES, ALL_ONES);
        end_burst();
        wait_idle();
    endtask

    // modulus one and zero, zero counts, widest modulus, saturated count
    task automatic test_edge_configs();
        configure(60'd1, 16'd2, 16'd2, 13'd2);
        for (int i = 0; i < 4; i++)
            send_item(ALL_ONES, 60'(i + 5));
        end_burst();
        wait_idle();
        configure(60'd0, 16'd0, 16'd0, 13'd0);
        send_item(60'd7, 60'd9);
        send_item(60'd3, 60'd4);
        end_burst();
        wait_idle();
        configure(ALL_ONES, 16'd3, 16'd2, 13'd1);
        for (int i = 0; i < 6; i++)
            send_item(ALL_ONES - 60'(i), ALL_ONES - 60'(2 * i + 1));
        end_burst();
        wait_idle();
        configure(60'd97, 16'd1, 16'd65535, 13'd8191);
        send_item(60'd200, 60'd96);
        send_item(60'd96, 60'd96);
        end_burst();
        wait_idle();
    endtask

    // configuration changed in the middle of a column
    task automatic test_midstream_change();
        configure(60'd1009, 16'd3, 16'd2, 13'd4);
        for (int i = 0; i < 6; i++)
            send_item(60'(i + 2), 60'(i * 100));
        end_burst();
        wait_idle();
        configure(60'd1013, 16'd2, 16'd65535, 13'd1);
        for (int i = 0; i < 3; i++)
            send_item(60'(i + 11), 60'(i + 900));
        end_burst();
        wait_idle();
    endtask

    // random configurations and bursts of random coefficients
    task automatic test_random_stream(input int n_items);
        int sent;
        int burst;
        sent = 0;
        while (sent < n_items)
        begin
            configure(pick_modulus(),
                      ($urandom_range(7) == 0) ? 16'($urandom_range(8, 20))
                                                : 16'($urandom_range(0, 4)),
                      16'($urandom_range(0, 4)),
                      ($urandom_range(9) == 0) ? 13'($urandom_range(4097, 8191))
                                                : 13'($urandom_range(0, 12)));
            burst = $urandom_range(15, 70);
            for (int i = 0; i < burst; i++)
                send_item(pick_value(), pick_value());
            sent += burst;
            end_burst();
            wait_idle();
        end
    endtask

    // receiver holds off long enough that the input channel stalls
    task automatic test_output_hold();
        configure(60'd65521, 16'd1, 16'd3, 13'd5);
        @(negedge clk);
        rx_hold_left = 400;
        for (int i = 0; i < 250; i++)
            send_item(pick_value(), pick_value());
        end_burst();
        wait_idle();
    endtask

    // sender pauses until every result is in, then resumes mid-column
    task automatic test_sender_pause();
        configure(60'd12289, 16'd2, 16'd2, 13'd3);
        for (int i = 0; i < 5; i++)
            send_item(pick_value(), pick_value());
        end_burst();
        while (expected_sums.size() != 0)
            @(posedge clk);
        for (int i = 0; i < 13; i++)
            send_item(pick_value(), pick_value());
        end_burst();
        wait_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        out_ready = 1'b0;
        rx_hold_left = 0;
        mismatch_count = 0;
        mdl_cfg.modulus = 60'd65537;
        mdl_cfg.row_count = 16'd1;
        mdl_cfg.col_count = 16'd1;
        mdl_cfg.coeffs_in_use = 13'd4096;
        row_pos = 0;
        col_pos = 0;
        coef_pos = 0;
        for (int i = 0; i < NCOEF_MAX; i++)
        begin
            acc_mem[i] = '0;
            acc_written[i] = 1'b0;
        end
        tx_idle_pct = 13;
        rx_idle_pct = 55;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_reset_config();
        test_edge_configs();
        test_midstream_change();
        test_random_stream(150);
        tx_idle_pct = 55;
        rx_idle_pct = 13;
        test_random_stream(150);
        test_sender_pause();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_stream(150);
        test_output_hold();

        wait_idle();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/mvpp_pkg.sv
rtl/core/mvpp_ram.sv
rtl/core/mvpp_cfg.sv
rtl/core/mvpp_mulmod.sv
rtl/core/modular_vector_polymatrix_product_core.sv
tb/sv/tb_modular_vector_polymatrix_product_core.sv
